// ----- rtl/uls_pkg.sv -----
// Shared types, constants and byte classes for the UTF-8 line sanitizer.
// Used by the step, queue and top-level modules; depends on nothing else.
package uls_pkg;

   localparam int CAP_W        = 9;     // width of the capacity register
   localparam int CNT_W        = 9;     // written-count width, covers any capacity
   localparam int MAX_CAPACITY = 256;
   localparam int MAX_RESULTS  = 5;     // most items one input byte can cause
   localparam int QUEUE_DEPTH  = 8;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(72);
   // Clamp bound, limited to what the register can express anyway.
   localparam logic [CAP_W-1:0] CAP_LIMIT =
      (MAX_CAPACITY > (1 << CAP_W) - 1) ? CAP_W'((1 << CAP_W) - 1) : CAP_W'(MAX_CAPACITY);

   localparam logic [7:0] BYTE_NUL     = 8'h00;
   localparam logic [7:0] BYTE_SPACE   = 8'h20;
   localparam logic [7:0] BYTE_QMARK   = 8'h3F;
   localparam logic [7:0] BYTE_DEL     = 8'h7F;
   localparam logic [7:0] CONT_LO      = 8'h80;
   localparam logic [7:0] CONT_HI      = 8'hBF;
   localparam logic [7:0] LEAD2_LO     = 8'hC2;
   localparam logic [7:0] LEAD2_HI     = 8'hDF;
   localparam logic [7:0] LEAD3_LO     = 8'hE0;
   localparam logic [7:0] LEAD3_HI     = 8'hEF;
   localparam logic [7:0] LEAD4_LO     = 8'hF0;
   localparam logic [7:0] LEAD4_HI     = 8'hF4;
   localparam logic [7:0] LEAD_SURR    = 8'hED;
   localparam logic [7:0] E0_MIN       = 8'hA0;
   localparam logic [7:0] ED_MAX       = 8'h9F;
   localparam logic [7:0] F0_MIN       = 8'h90;
   localparam logic [7:0] F4_MAX       = 8'h8F;

   typedef struct packed {
      logic [7:0] text_length;
      logic [7:0] out_byte;
      logic       is_end;
   } result_type;

   typedef struct packed {
      logic [2:0][7:0]    held;
      logic [1:0]         held_count;
      logic [2:0]         exp_width;
      logic [CNT_W-1:0]   written;
      logic               finished;
   } state_type;

   // Character width from a lead byte; zero for a byte that cannot lead.
   function automatic logic [2:0] lead_width(input logic [7:0] b);
      logic [2:0] w;
      w = 3'd0;
      if (b < CONT_LO)                          w = 3'd1;
      else if (b >= LEAD2_LO && b <= LEAD2_HI)  w = 3'd2;
      else if (b >= LEAD3_LO && b <= LEAD3_HI)  w = 3'd3;
      else if (b >= LEAD4_LO && b <= LEAD4_HI)  w = 3'd4;
      return w;
   endfunction

endpackage

// ----- rtl/uls_step.sv -----
// Per-byte decode step: from the current state and one input byte, the list
// of result items and the next state. Purely combinational; uses uls_pkg.
module uls_step (
   input  uls_pkg::state_type                            state,
   input  logic [7:0]                                    in_byte,
   input  logic                                          is_last,
   input  logic [uls_pkg::CAP_W-1:0]                     capacity,
   output uls_pkg::state_type                            state_next,
   output uls_pkg::result_type [uls_pkg::MAX_RESULTS-1:0] results,
   output logic [2:0]                                    result_count
);
   import uls_pkg::*;

   function automatic logic fits(input logic [CNT_W-1:0] room, input logic [2:0] used,
                                 input logic [2:0] w);
      return (CNT_W'(used) + CNT_W'(w)) <= room;
   endfunction

   logic [CAP_W-1:0] cap_eff;
   logic [CNT_W-1:0] room;

   always_comb begin
      if (capacity == '0)            cap_eff = CAP_W'(1);
      else if (capacity > CAP_LIMIT) cap_eff = CAP_LIMIT;
      else                           cap_eff = capacity;
      // a count at or past the capacity (capacity lowered mid-text) leaves no room
      room = (CNT_W'(cap_eff) > state.written) ?
             CNT_W'(cap_eff) - CNT_W'(1) - state.written : '0;
   end

   always_comb begin
      state_type          nx;
      result_type [MAX_RESULTS-1:0] res;
      logic [2:0]         n;
      logic               stop;
      logic               term;
      logic               lead_mode;
      logic               ok;
      logic [2:0]         w;
      logic [7:0]         lead;

      nx        = state;
      res       = '0;
      n         = 3'd0;
      stop      = 1'b0;
      term      = 1'b0;
      lead_mode = 1'b0;
      lead      = state.held[0];
      w         = lead_width(in_byte);
      ok        = (in_byte >= CONT_LO) && (in_byte <= CONT_HI);
      if (ok && state.held_count == 2'd1 && state.exp_width >= 3'd3) begin
         if ((lead == LEAD3_LO && in_byte < E0_MIN) || (lead == LEAD_SURR && in_byte > ED_MAX) ||
             (lead == LEAD4_LO && in_byte < F0_MIN) || (lead == LEAD4_HI && in_byte > F4_MAX))
            ok = 1'b0;
      end

      if (state.finished) begin
         if (is_last) nx.finished = 1'b0;
      end else begin
         if (state.held_count == 2'd0) begin
            lead_mode = 1'b1;
         end else if (!ok) begin
            // bad sequence: one '?' per held byte, then retry this byte as a lead
            for (int i = 0; i < 3; i++) begin
               if (2'(i) < state.held_count && !stop) begin
                  if (fits(room, n, 3'd1)) begin
                     res[n].out_byte = BYTE_QMARK;
                     n = n + 3'd1;
                  end else begin
                     stop = 1'b1;
                  end
               end
            end
            nx.held_count = 2'd0;
            nx.exp_width  = 3'd0;
            lead_mode     = !stop;
         end else if ((3'(state.held_count) + 3'd1) < state.exp_width &&
                      state.held_count < 2'd3) begin
            nx.held[state.held_count] = in_byte;
            nx.held_count             = state.held_count + 2'd1;
         end else if (fits(room, n, state.exp_width)) begin
            for (int i = 0; i < 3; i++) begin
               if (2'(i) < state.held_count) begin
                  res[n].out_byte = state.held[i];
                  n = n + 3'd1;
               end
            end
            res[n].out_byte = in_byte;
            n = n + 3'd1;
            nx.held_count = 2'd0;
            nx.exp_width  = 3'd0;
         end else begin
            stop = 1'b1;
         end

         if (lead_mode) begin
            if (in_byte == BYTE_NUL) begin
               term = 1'b1;
            end else if (w == 3'd0 || w == 3'd1) begin
               if (fits(room, n, 3'd1)) begin
                  if (w == 3'd0)
                     res[n].out_byte = BYTE_QMARK;
                  else if (in_byte < BYTE_SPACE || in_byte == BYTE_DEL)
                     res[n].out_byte = BYTE_SPACE;
                  else
                     res[n].out_byte = in_byte;
                  n = n + 3'd1;
               end else begin
                  stop = 1'b1;
               end
            end else begin
               nx.held[0]    = in_byte;
               nx.held_count = 2'd1;
               nx.exp_width  = w;
            end
         end

         // end of text: flush whatever is still held as '?'
         if (!stop && !term && is_last) begin
            for (int i = 0; i < 3; i++) begin
               if (2'(i) < nx.held_count && !stop) begin
                  if (fits(room, n, 3'd1)) begin
                     res[n].out_byte = BYTE_QMARK;
                     n = n + 3'd1;
                  end else begin
                     stop = 1'b1;
                  end
               end
            end
            nx.held_count = 2'd0;
            nx.exp_width  = 3'd0;
         end

         nx.written = state.written + CNT_W'(n);
         if (stop || term || is_last) begin
            res[n].out_byte    = BYTE_NUL;
            res[n].is_end      = 1'b1;
            res[n].text_length = nx.written[7:0];
            n = n + 3'd1;
            nx.held       = '0;
            nx.held_count = 2'd0;
            nx.exp_width  = 3'd0;
            nx.written    = '0;
            nx.finished   = !is_last;
         end
      end

      state_next   = nx;
      results      = res;
      result_count = n;
   end

endmodule

// ----- rtl/uls_result_queue.sv -----
// Result queue: takes a burst of up to MAX_RESULTS items per cycle and
// drains them to the stream output one item per cycle while out_ready is high. Uses uls_pkg.
module uls_result_queue (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           push,
   input  uls_pkg::result_type [uls_pkg::MAX_RESULTS-1:0] push_items,
   input  logic [2:0]                                     push_count,
   output logic                                           has_room,
   output logic                                           out_valid,
   input  logic                                           out_ready,
   output uls_pkg::result_type                            out_item
);
   import uls_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

   result_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [OCC_W-1:0]       occ_ff, occ_in;
   logic                   pop;
   logic [2:0]             add;

   assign pop       = out_valid && out_ready;
   assign add       = push ? push_count : 3'd0;
   assign out_valid = occ_ff != '0;
   assign out_item  = slot_ff[rd_ptr_ff];
   // room for a whole burst, from registered state only
   assign has_room  = occ_ff <= OCC_W'(QUEUE_DEPTH - MAX_RESULTS);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(add);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      occ_in    = occ_ff + OCC_W'(add) - OCC_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         occ_ff    <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (push && 3'(k) < push_count)
            slot_ff[PTR_W'(wr_ptr_ff + PTR_W'(k))] <= push_items[k];
      end
   end

endmodule

// ----- rtl/utf8_line_sanitizer.sv -----
// Top level of the UTF-8 line sanitizer: input register, decode state,
// capacity register and result queue. Uses uls_pkg, uls_step, uls_result_queue.
//
// Usage:
//  req_*  : source text, one byte per item, req_tlast on the final byte.
//  rsp_*  : cleaned bytes, one per item; the terminator item has rsp_tlast
//           high, a zero byte and the text length in tdata[15:8].
//  csr_*  : writes output_capacity (always ready); write only while idle.
//  Path: a byte is taken into the input register, then its result items are
//  written into the result queue; the byte waits there while the queue lacks room.
//  Throughput: one byte per cycle while each byte gives at most one item and rsp_tready is high.
//  A byte can give up to 5 items (flushed '?', a character, the
//  terminator), which leave the output one at a time; the result queue is 8 deep
//  and the input register waits while it holds more than 3 items, so the
//  output drain rate sets the pace.
//  Bytes swallowed after an early end give no item.
//  Reset: synchronous, clears the decode state and the queue and sets the
//  capacity to 72. A stalled receiver fills the queue and then backs up
//  the input through req_tready; no item is lost.
module utf8_line_sanitizer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] in_byte
   input  logic                      req_tlast,   // is_last
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [15:0]               rsp_tdata,   // [7:0] out_byte, [15:8] text_length
   output logic                      rsp_tlast,   // is_end
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [uls_pkg::CAP_W-1:0] csr_data     // output_capacity
);
   import uls_pkg::*;

   logic                         in_valid_ff;
   logic [7:0]                   in_byte_ff;
   logic                         in_last_ff;
   logic [CAP_W-1:0]             cap_ff;
   state_type                    state_ff, state_in;
   result_type [MAX_RESULTS-1:0] step_items;
   logic [2:0]                   step_count;
   logic                         queue_room;
   logic                         step_go;
   result_type                   head;

   assign step_go    = in_valid_ff && queue_room;
   assign req_tready = !in_valid_ff || queue_room;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_data;
      end
   end

   uls_step u_step (
      .state        (state_ff),
      .in_byte      (in_byte_ff),
      .is_last      (in_last_ff),
      .capacity     (cap_ff),
      .state_next   (state_in),
      .results      (step_items),
      .result_count (step_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step_go) begin
         state_ff <= state_in;
      end
   end

   uls_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (step_go),
      .push_items (step_items),
      .push_count (step_count),
      .has_room   (queue_room),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (head)
   );

   assign rsp_tdata = {head.text_length, head.out_byte};
   assign rsp_tlast = head.is_end;

endmodule

// ----- rtl/uls_checker.sv -----
// Port-level checks for the UTF-8 line sanitizer, bound to the top level.
// Depends only on the top-level ports.
module uls_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[7:0] == 8'h00)
      else $error("terminator with nonzero byte");

   a_len_only_on_term: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[15:8] == 8'h00)
      else $error("length on a text item");

   // cleaned text never carries control bytes or DEL
   a_no_ctrl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[7:0] >= 8'h20 && rsp_tdata[7:0] != 8'h7F)
      else $error("control byte in cleaned text");

endmodule

bind utf8_line_sanitizer uls_checker u_uls_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
